// ===== rtl/losg_pkg.sv =====
`timescale 1ns / 1ps

package losg_pkg;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        linear_speed;
        logic signed [15:0] turn_rate;
        logic signed [15:0] desired_course;
        logic               path_done;
    } t_out_item;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_POSE   = 2'd2;

    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_MAX_SPEED       = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_MAX_TURN_SPEED  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_MIN_SPEED       = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_LOOKAHEAD_MAX   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_LOOKAHEAD_MIN   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_LOOKAHEAD_DECAY = 3'd5;

    localparam logic [15:0] RST_MAX_SPEED       = 16'd1638;
    localparam logic [15:0] RST_MAX_TURN_SPEED  = 16'd2458;
    localparam logic [15:0] RST_MIN_SPEED       = 16'd0;
    localparam logic [15:0] RST_LOOKAHEAD_MAX   = 16'd512;
    localparam logic [15:0] RST_LOOKAHEAD_MIN   = 16'd128;
    localparam logic [15:0] RST_LOOKAHEAD_DECAY = 16'd256;

    localparam int CORDIC_XW    = 40;
    localparam int CORDIC_ZW    = 21;
    localparam int CORDIC_CW    = 4;
    localparam logic [CORDIC_CW-1:0] CORDIC_LAST = 4'd15;
    localparam logic signed [CORDIC_XW-1:0] CORDIC_INV_GAIN = 40'sd652032874;

    localparam logic [32:0] LOG2E_Q16  = 33'd94548;
    localparam logic [32:0] TWO_PI_Q16 = 33'd411775;
    localparam logic [32:0] RECIP5_Q21 = 33'd419431;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_X, S_SCAN_Y, S_SCAN_LAST, S_FETCH, S_HEAD, S_NEXT, S_SIN,
        S_YE1, S_YE2, S_YE3, S_DEC0, S_DEC1, S_DEC2, S_DEC3, S_EXP0, S_EXP1,
        S_EXP2, S_EXP3, S_EXP4, S_LOOK, S_LOOK2, S_ATAN, S_ERR, S_SPD0, S_SPD1,
        S_SPD2, S_SPD3, S_TR1, S_TR2, S_OUT
    } t_state;

    function automatic logic signed [CORDIC_ZW-1:0] atan_tab(input logic [CORDIC_CW-1:0] idx);
        logic signed [CORDIC_ZW-1:0] v;
        unique case (idx)
            4'd0:    v = 21'sd131072;
            4'd1:    v = 21'sd77376;
            4'd2:    v = 21'sd40884;
            4'd3:    v = 21'sd20753;
            4'd4:    v = 21'sd10417;
            4'd5:    v = 21'sd5213;
            4'd6:    v = 21'sd2607;
            4'd7:    v = 21'sd1304;
            4'd8:    v = 21'sd652;
            4'd9:    v = 21'sd326;
            4'd10:   v = 21'sd163;
            4'd11:   v = 21'sd81;
            4'd12:   v = 21'sd41;
            4'd13:   v = 21'sd20;
            4'd14:   v = 21'sd10;
            default: v = 21'sd5;
        endcase
        return v;
    endfunction

    function automatic logic [29:0] pow2neg(input logic [2:0] idx);
        logic [29:0] v;
        unique case (idx)
            3'd0:    v = 30'd759250125;
            3'd1:    v = 30'd902905697;
            3'd2:    v = 30'd984625594;
            3'd3:    v = 30'd1028218693;
            3'd4:    v = 30'd1050733751;
            3'd5:    v = 30'd1062175491;
            3'd6:    v = 30'd1067942999;
            default: v = 30'd1070838487;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/losg_cordic.sv =====
`timescale 1ns / 1ps

module losg_cordic (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_vector,
    input  logic signed [losg_pkg::CORDIC_XW-1:0] i_x,
    input  logic signed [losg_pkg::CORDIC_XW-1:0] i_y,
    input  logic signed [losg_pkg::CORDIC_ZW-1:0] i_z,
    output logic                                  o_done,
    output logic signed [losg_pkg::CORDIC_XW-1:0] o_x,
    output logic signed [losg_pkg::CORDIC_XW-1:0] o_y,
    output logic signed [losg_pkg::CORDIC_ZW-1:0] o_z
);

    logic signed [losg_pkg::CORDIC_XW-1:0] r_x, r_y, xs, ys;
    logic signed [losg_pkg::CORDIC_ZW-1:0] r_z, ang;
    logic [losg_pkg::CORDIC_CW-1:0]        r_cnt;
    logic                                  r_busy, r_vec, r_done, dir;

    assign xs  = r_x >>> r_cnt;
    assign ys  = r_y >>> r_cnt;
    assign ang = losg_pkg::atan_tab(r_cnt);
    assign dir = r_vec ? r_y[losg_pkg::CORDIC_XW-1] : !r_z[losg_pkg::CORDIC_ZW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == losg_pkg::CORDIC_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_vec <= i_vector;
        end else if (r_busy) begin
            if (dir) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - ang;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + ang;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

// ===== rtl/line_of_sight_path_guidance.sv =====
`timescale 1ns / 1ps
// Clear and append beats are handled in the idle state. For a pose beat on a path
// that is not finished, the nearest-waypoint scan squares the X and Y distances of
// each remaining waypoint on the shared multiplier, then the shift-add CORDIC unit
// runs a rotation pass and, if the cross-track error is nonzero, a vectoring pass. One beat is processed at a time.
// Reset clears the sequencer, the path indices and the output valid, and loads
// the register defaults; the waypoint store is not cleared.
module line_of_sight_path_guidance #(
    parameter int PATH_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  losg_pkg::t_in_item             i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output losg_pkg::t_out_item            o_out_data,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [losg_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);

    localparam int AW = $clog2(PATH_DEPTH);

    losg_pkg::t_state r_state, n_state;

    logic [15:0] r_max_speed, r_max_turn, r_min_speed, r_la_max, r_la_min, r_decay;

    logic [31:0] r_way_x [PATH_DEPTH];
    logic [31:0] r_way_y [PATH_DEPTH];
    logic [15:0] r_way_h [PATH_DEPTH];
    logic [31:0] r_rd_x, r_rd_y;
    logic [15:0] r_rd_h;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    logic [AW-1:0] r_first, r_best, r_cidx;
    logic [AW:0]   r_end, r_idx;

    logic in_acc, finished, out_free;

    logic signed [31:0] r_px, r_py;
    logic signed [15:0] r_yaw, r_gam;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] r_prod, r_acc, ye_sum;

    logic signed [32:0] scan_dx, scan_dy, adx, ady;
    logic [31:0]        r_ady;
    logic [63:0]        r_d1;
    logic [64:0]        r_best_d, dist_sum;
    logic               r_pend, better;

    logic signed [32:0] r_dx, r_dy, head_dx, head_dy;
    logic               r_rneg, r_turning, r_pdone;
    logic signed [20:0] z_in, z_pre;
    logic               z_neg;
    logic signed [17:0] r_sn, r_cs;
    logic signed [39:0] x_fix, y_fix, cs_sum, sn_sum;

    logic signed [35:0] r_ye, ye_val, ye_abs;
    logic [34:0]        r_ay;
    logic [47:0]        r_sq;
    logic [40:0]        r_a16, a16_sum;
    logic [4:0]         r_n;
    logic [7:0]         r_f8;
    logic [30:0]        r_r, r_shift;
    logic [3:0]         r_j;
    logic               exp_bit;
    logic [31:0]        fac_sum;
    logic [16:0]        r_factor;

    logic signed [32:0] look_diff, delta_sum;
    logic [15:0]        delta16;

    logic               cor_start, cor_vec, cor_done;
    logic signed [39:0] cor_x0, cor_y0, cor_x, cor_y;
    logic signed [20:0] cor_z0, cor_z, chir_sum;
    logic [15:0]        r_chir, chi, err;
    logic signed [16:0] err_ext;
    logic [16:0]        r_aerr;
    logic               r_eneg, r_big;

    logic signed [19:0] r_f, f_calc;
    logic signed [18:0] u_val;
    logic [17:0]        mag;
    logic [15:0]        mag_c, tr_val;

    losg_pkg::t_out_item r_res, r_out;
    logic                r_out_valid;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != losg_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign finished   = (r_end <= ({1'b0, r_first} + (AW+1)'(1)));
    assign mem_we     = in_acc && (i_in_data.cmd == losg_pkg::CMD_APPEND)
                        && (r_end < (AW+1)'(PATH_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= losg_pkg::RST_MAX_SPEED;
            r_max_turn  <= losg_pkg::RST_MAX_TURN_SPEED;
            r_min_speed <= losg_pkg::RST_MIN_SPEED;
            r_la_max    <= losg_pkg::RST_LOOKAHEAD_MAX;
            r_la_min    <= losg_pkg::RST_LOOKAHEAD_MIN;
            r_decay     <= losg_pkg::RST_LOOKAHEAD_DECAY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                losg_pkg::CFG_MAX_SPEED:       r_max_speed <= i_cfg_data;
                losg_pkg::CFG_MAX_TURN_SPEED:  r_max_turn  <= i_cfg_data;
                losg_pkg::CFG_MIN_SPEED:       r_min_speed <= i_cfg_data;
                losg_pkg::CFG_LOOKAHEAD_MAX:   r_la_max    <= i_cfg_data;
                losg_pkg::CFG_LOOKAHEAD_MIN:   r_la_min    <= i_cfg_data;
                losg_pkg::CFG_LOOKAHEAD_DECAY: r_decay     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (r_state)
            losg_pkg::S_IDLE:   rd_addr = r_first;
            losg_pkg::S_SCAN_X,
            losg_pkg::S_SCAN_Y: rd_addr = r_idx[AW-1:0] + AW'(1);
            losg_pkg::S_FETCH:  rd_addr = r_best;
            default:            rd_addr = r_best + AW'(1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_way_x[r_end[AW-1:0]] <= i_in_data.pos_x;
            r_way_y[r_end[AW-1:0]] <= i_in_data.pos_y;
            r_way_h[r_end[AW-1:0]] <= i_in_data.heading;
        end
        r_rd_x <= r_way_x[rd_addr];
        r_rd_y <= r_way_y[rd_addr];
        r_rd_h <= r_way_h[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_end   <= '0;
        end else if (in_acc && (i_in_data.cmd == losg_pkg::CMD_CLEAR)) begin
            r_first <= '0;
            r_end   <= '0;
        end else if (mem_we) begin
            r_end <= r_end + (AW+1)'(1);
        end else if (r_state == losg_pkg::S_HEAD) begin
            r_first <= r_best;
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            losg_pkg::S_SCAN_X: begin
                mul_a = {1'b0, adx[31:0]};
                mul_b = {1'b0, adx[31:0]};
            end
            losg_pkg::S_SCAN_Y: begin
                mul_a = {1'b0, r_ady};
                mul_b = {1'b0, r_ady};
            end
            losg_pkg::S_YE1: begin
                mul_a = r_dx;
                mul_b = {{15{r_sn[17]}}, r_sn};
            end
            losg_pkg::S_YE2: begin
                mul_a = r_dy;
                mul_b = {{15{r_cs[17]}}, r_cs};
            end
            losg_pkg::S_DEC0: begin
                mul_a = {9'b0, r_ay[23:0]};
                mul_b = {9'b0, r_ay[23:0]};
            end
            losg_pkg::S_DEC1: begin
                mul_a = {9'b0, r_prod[47:24]};
                mul_b = {17'b0, r_decay};
            end
            losg_pkg::S_DEC2: begin
                mul_a = {9'b0, r_sq[23:0]};
                mul_b = {17'b0, r_decay};
            end
            losg_pkg::S_EXP0: begin
                mul_a = {12'b0, r_a16[20:0]};
                mul_b = losg_pkg::LOG2E_Q16;
            end
            losg_pkg::S_EXP2: begin
                mul_a = {2'b0, r_r};
                mul_b = {3'b0, losg_pkg::pow2neg(r_j[2:0])};
            end
            losg_pkg::S_LOOK: begin
                mul_a = look_diff;
                mul_b = {16'b0, r_factor};
            end
            losg_pkg::S_SPD0: begin
                mul_a = {14'b0, r_ay[18:0]};
                mul_b = losg_pkg::RECIP5_Q21;
            end
            losg_pkg::S_SPD2: begin
                mul_a = {17'b0, r_max_speed};
                mul_b = {{13{r_f[19]}}, r_f};
            end
            losg_pkg::S_SPD3: begin
                mul_a = {17'b0, r_max_turn};
                mul_b = {16'b0, r_aerr};
            end
            losg_pkg::S_TR1: begin
                mul_a = {1'b0, r_prod[31:0]};
                mul_b = losg_pkg::TWO_PI_Q16;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_comb begin
        scan_dx  = $signed({r_px[31], r_px}) - $signed({r_rd_x[31], r_rd_x});
        scan_dy  = $signed({r_py[31], r_py}) - $signed({r_rd_y[31], r_rd_y});
        adx      = scan_dx[32] ? -scan_dx : scan_dx;
        ady      = scan_dy[32] ? -scan_dy : scan_dy;
        dist_sum = {1'b0, r_d1} + {1'b0, r_prod[63:0]};
        better   = (r_cidx == r_first) || (dist_sum < r_best_d);
        head_dx  = scan_dx;
        head_dy  = scan_dy;

        z_in  = {r_gam[15], r_gam, 4'b0};
        z_pre = z_in;
        z_neg = 1'b0;
        if (z_in > 21'sd262144) begin
            z_pre = z_in - 21'sd524288;
            z_neg = 1'b1;
        end else if (z_in < -21'sd262144) begin
            z_pre = z_in + 21'sd524288;
            z_neg = 1'b1;
        end
        x_fix  = r_rneg ? -cor_x : cor_x;
        y_fix  = r_rneg ? -cor_y : cor_y;
        cs_sum = x_fix + 40'sd16384;
        sn_sum = y_fix + 40'sd16384;

        ye_sum = r_acc + r_prod;
        ye_val = ye_sum[50:15];
        ye_abs = ye_val[35] ? -ye_val : ye_val;

        a16_sum = r_a16 + {25'b0, r_prod[39:24]};
        exp_bit = r_f8[3'd7 - r_j[2:0]];
        r_shift = r_r >> r_n;
        fac_sum = {1'b0, r_shift} + 32'd8192;

        look_diff = $signed({17'b0, r_la_max}) - $signed({17'b0, r_la_min});
        delta_sum = $signed({17'b0, r_la_min}) + $signed(r_prod[48:16]);
        delta16   = r_turning ? r_la_min : delta_sum[15:0];

        chir_sum = cor_z + 21'sd8;
        chi      = r_gam + r_chir;
        err      = chi - r_yaw;
        err_ext  = {err[15], err};
        f_calc   = 20'sd65536 - $signed({3'b0, r_prod[37:21]})
                   - $signed({1'b0, r_aerr, 2'b0});
        u_val    = $signed(r_prod[34:16]);
        mag      = r_prod[49:32];
        mag_c    = (mag > {2'b0, r_max_turn}) ? r_max_turn : mag[15:0];
        if (!r_eneg) begin
            tr_val = (mag_c > 16'd32767) ? 16'h7fff : mag_c;
        end else begin
            tr_val = (mag_c > 16'd32768) ? 16'h8000 : (16'd0 - mag_c);
        end
    end

    always_comb begin
        cor_start = 1'b0;
        cor_vec   = 1'b0;
        cor_x0    = losg_pkg::CORDIC_INV_GAIN;
        cor_y0    = '0;
        cor_z0    = z_pre;
        if (r_state == losg_pkg::S_NEXT) begin
            cor_start = 1'b1;
        end else if (r_state == losg_pkg::S_LOOK2) begin
            cor_start = (r_ye != '0);
            cor_vec   = 1'b1;
            cor_x0    = {16'b0, delta16, 8'b0};
            cor_y0    = -{{4{r_ye[35]}}, r_ye};
            cor_z0    = '0;
        end
    end

    losg_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cor_start),
        .i_vector (cor_vec),
        .i_x      (cor_x0),
        .i_y      (cor_y0),
        .i_z      (cor_z0),
        .o_done   (cor_done),
        .o_x      (cor_x),
        .o_y      (cor_y),
        .o_z      (cor_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= losg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            losg_pkg::S_IDLE: begin
                if (in_acc && (i_in_data.cmd == losg_pkg::CMD_POSE)) begin
                    n_state = finished ? losg_pkg::S_OUT : losg_pkg::S_SCAN_X;
                end
            end
            losg_pkg::S_SCAN_X:    n_state = losg_pkg::S_SCAN_Y;
            losg_pkg::S_SCAN_Y: begin
                n_state = (r_idx + (AW+1)'(1) == r_end) ? losg_pkg::S_SCAN_LAST
                                                         : losg_pkg::S_SCAN_X;
            end
            losg_pkg::S_SCAN_LAST: n_state = losg_pkg::S_FETCH;
            losg_pkg::S_FETCH:     n_state = losg_pkg::S_HEAD;
            losg_pkg::S_HEAD:      n_state = losg_pkg::S_NEXT;
            losg_pkg::S_NEXT:      n_state = losg_pkg::S_SIN;
            losg_pkg::S_SIN:       n_state = cor_done ? losg_pkg::S_YE1 : losg_pkg::S_SIN;
            losg_pkg::S_YE1:       n_state = losg_pkg::S_YE2;
            losg_pkg::S_YE2:       n_state = losg_pkg::S_YE3;
            losg_pkg::S_YE3:       n_state = losg_pkg::S_DEC0;
            losg_pkg::S_DEC0: begin
                n_state = ((r_decay == '0) || (r_ay[34:24] != '0)) ? losg_pkg::S_LOOK
                                                                  : losg_pkg::S_DEC1;
            end
            losg_pkg::S_DEC1:      n_state = losg_pkg::S_DEC2;
            losg_pkg::S_DEC2:      n_state = losg_pkg::S_DEC3;
            losg_pkg::S_DEC3: begin
                n_state = (a16_sum[40:21] != '0) ? losg_pkg::S_LOOK : losg_pkg::S_EXP0;
            end
            losg_pkg::S_EXP0:      n_state = losg_pkg::S_EXP1;
            losg_pkg::S_EXP1: begin
                n_state = (r_prod[37:32] >= 6'd31) ? losg_pkg::S_LOOK : losg_pkg::S_EXP2;
            end
            losg_pkg::S_EXP2: begin
                if (r_j[3]) begin
                    n_state = losg_pkg::S_EXP4;
                end else if (exp_bit) begin
                    n_state = losg_pkg::S_EXP3;
                end
            end
            losg_pkg::S_EXP3:      n_state = losg_pkg::S_EXP2;
            losg_pkg::S_EXP4:      n_state = losg_pkg::S_LOOK;
            losg_pkg::S_LOOK:      n_state = losg_pkg::S_LOOK2;
            losg_pkg::S_LOOK2: begin
                n_state = (r_ye == '0) ? losg_pkg::S_ERR : losg_pkg::S_ATAN;
            end
            losg_pkg::S_ATAN:      n_state = cor_done ? losg_pkg::S_ERR : losg_pkg::S_ATAN;
            losg_pkg::S_ERR:       n_state = losg_pkg::S_SPD0;
            losg_pkg::S_SPD0:      n_state = losg_pkg::S_SPD1;
            losg_pkg::S_SPD1:      n_state = losg_pkg::S_SPD2;
            losg_pkg::S_SPD2:      n_state = losg_pkg::S_SPD3;
            losg_pkg::S_SPD3:      n_state = losg_pkg::S_TR1;
            losg_pkg::S_TR1:       n_state = losg_pkg::S_TR2;
            losg_pkg::S_TR2:       n_state = losg_pkg::S_OUT;
            losg_pkg::S_OUT:       n_state = out_free ? losg_pkg::S_IDLE : losg_pkg::S_OUT;
            default:               n_state = losg_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (r_state == losg_pkg::S_IDLE) begin
            r_pend <= 1'b0;
        end else if (r_state == losg_pkg::S_SCAN_Y) begin
            r_pend <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            losg_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_px  <= i_in_data.pos_x;
                    r_py  <= i_in_data.pos_y;
                    r_yaw <= i_in_data.heading;
                end
                r_idx <= {1'b0, r_first};
                r_res <= '{linear_speed: '0, turn_rate: '0, desired_course: '0,
                           path_done: 1'b1};
            end
            losg_pkg::S_SCAN_X: begin
                r_ady <= ady[31:0];
                if (r_pend && better) begin
                    r_best   <= r_cidx;
                    r_best_d <= dist_sum;
                end
            end
            losg_pkg::S_SCAN_Y: begin
                r_d1   <= r_prod[63:0];
                r_cidx <= r_idx[AW-1:0];
                r_idx  <= r_idx + (AW+1)'(1);
            end
            losg_pkg::S_SCAN_LAST: begin
                if (better) begin
                    r_best   <= r_cidx;
                    r_best_d <= dist_sum;
                end
            end
            losg_pkg::S_HEAD: begin
                r_dx  <= head_dx;
                r_dy  <= head_dy;
                r_gam <= r_rd_h;
            end
            losg_pkg::S_NEXT: begin
                r_turning <= (({1'b0, r_best} + (AW+1)'(1)) < r_end) && (r_rd_h != r_gam);
                r_pdone   <= ((r_end - {1'b0, r_best}) <= (AW+1)'(1));
                r_rneg    <= z_neg;
            end
            losg_pkg::S_SIN: begin
                if (cor_done) begin
                    r_cs <= cs_sum[32:15];
                    r_sn <= sn_sum[32:15];
                end
            end
            losg_pkg::S_YE2: r_acc <= -r_prod;
            losg_pkg::S_YE3: begin
                r_ye <= ye_val;
                r_ay <= ye_abs[34:0];
            end
            losg_pkg::S_DEC0: begin
                r_factor <= (r_decay == '0) ? 17'd65536 : 17'd0;
            end
            losg_pkg::S_DEC1: r_sq <= r_prod[47:0];
            losg_pkg::S_DEC2: r_a16 <= {1'b0, r_prod[39:0]};
            losg_pkg::S_DEC3: begin
                r_a16    <= a16_sum;
                r_factor <= 17'd0;
            end
            losg_pkg::S_EXP1: begin
                r_n  <= r_prod[36:32];
                r_f8 <= r_prod[31:24];
                r_r  <= 31'h4000_0000;
                r_j  <= '0;
            end
            losg_pkg::S_EXP2: begin
                if (!r_j[3] && !exp_bit) begin
                    r_j <= r_j + 4'd1;
                end
            end
            losg_pkg::S_EXP3: begin
                r_r <= r_prod[60:30];
                r_j <= r_j + 4'd1;
            end
            losg_pkg::S_EXP4: r_factor <= fac_sum[30:14];
            losg_pkg::S_LOOK2: r_chir <= '0;
            losg_pkg::S_ATAN: begin
                if (cor_done) begin
                    r_chir <= chir_sum[19:4];
                end
            end
            losg_pkg::S_ERR: begin
                r_aerr <= err_ext[16] ? 17'(-err_ext) : 17'(err_ext);
                r_eneg <= err_ext[16];
                r_res.desired_course <= chi;
                r_res.path_done      <= r_pdone;
            end
            losg_pkg::S_SPD0: r_big <= (r_ay[34:19] != '0);
            losg_pkg::S_SPD1: r_f <= f_calc;
            losg_pkg::S_SPD3: begin
                if (r_turning) begin
                    r_res.linear_speed <= r_max_turn;
                end else if (r_big || (u_val < $signed({3'b0, r_min_speed}))) begin
                    r_res.linear_speed <= r_min_speed;
                end else begin
                    r_res.linear_speed <= u_val[15:0];
                end
            end
            losg_pkg::S_TR2: r_res.turn_rate <= tr_val;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == losg_pkg::S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == losg_pkg::S_OUT) && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
